@@ rtl/lsp_pkg.sv @@
`timescale 1ns / 1ps
// lsp_pkg: shared types and constants of the looping sample phasor
// no dependencies; used by every module of the block but lsp_div

package lsp_pkg;

    localparam int REG_W     = 40;
    localparam int TRIG_W    = 16;
    localparam int RATE_IN_W = 32;
    localparam int CFG_AW    = 2;
    localparam int TDATA_W   = 2 * TRIG_W + RATE_IN_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_START_POS   = 2'd0,
        CFG_END_POS     = 2'd1,
        CFG_LOOP_BEGIN  = 2'd2,
        CFG_LOOP_FINISH = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RDIV_GO,
        ST_RDIV,
        ST_RFIX,
        ST_WRAP,
        ST_MDIV_GO,
        ST_MDIV,
        ST_MFIX,
        ST_OUT
    } state_t;

    typedef enum logic {
        DIV_RESTART = 1'b0,
        DIV_WRAP    = 1'b1
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     eval;
        logic     div_start;
        div_sel_t div_sel;
        logic     rfix;
        logic     wrap;
        logic     mfix;
        logic     out_write;
    } dp_cmd_t;

    typedef struct packed {
        logic restart_edge;
        logic need_mod;
        logic div_busy;
        logic out_free;
    } dp_sts_t;

endpackage

@@ rtl/lsp_div.sv @@
`timescale 1ns / 1ps
// lsp_div: unsigned restoring divider, one quotient bit per cycle
// no package dependencies; instantiated by lsp_dp

module lsp_div #(
    parameter int DVD_W = 47,
    parameter int DVS_W = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   shift_val;
    logic [DVS_W:0]   diff_val;
    logic             fit;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_next;

    always_comb
    begin
        shift_val = {rem_reg, quo_reg[DVD_W-1]};
        diff_val  = shift_val - {1'b0, dvs_reg};
        fit       = (shift_val >= {1'b0, dvs_reg});
        rem_next  = fit ? diff_val[DVS_W-1:0] : shift_val[DVS_W-1:0];
        quo_next  = {quo_reg[DVD_W-2:0], fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/lsp_ctrl.sv @@
`timescale 1ns / 1ps
// lsp_ctrl: sequencer of the looping sample phasor
// depends on lsp_pkg; drives lsp_dp through command and status structs

module lsp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lsp_pkg::dp_sts_t  sts,
    output lsp_pkg::dp_cmd_t  cmd
);

    lsp_pkg::state_t state_reg;
    lsp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == lsp_pkg::ST_IDLE);
        unique case (state_reg)
            lsp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lsp_pkg::ST_EVAL;
                end
            end
            lsp_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.restart_edge ? lsp_pkg::ST_RDIV_GO : lsp_pkg::ST_WRAP;
            end
            lsp_pkg::ST_RDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lsp_pkg::DIV_RESTART;
                state_next    = lsp_pkg::ST_RDIV;
            end
            lsp_pkg::ST_RDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = lsp_pkg::ST_RFIX;
                end
            end
            lsp_pkg::ST_RFIX:
            begin
                cmd.rfix   = 1'b1;
                state_next = lsp_pkg::ST_WRAP;
            end
            lsp_pkg::ST_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = sts.need_mod ? lsp_pkg::ST_MDIV_GO : lsp_pkg::ST_OUT;
            end
            lsp_pkg::ST_MDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lsp_pkg::DIV_WRAP;
                state_next    = lsp_pkg::ST_MDIV;
            end
            lsp_pkg::ST_MDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = lsp_pkg::ST_MFIX;
                end
            end
            lsp_pkg::ST_MFIX:
            begin
                cmd.mfix   = 1'b1;
                state_next = lsp_pkg::ST_OUT;
            end
            lsp_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = lsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/lsp_dp.sv @@
`timescale 1ns / 1ps
// lsp_dp: phasor datapath with position state, restart offset, wrap and clamp
// depends on lsp_pkg and lsp_div; commanded by lsp_ctrl

module lsp_dp #(
    parameter int POS_FRAC_BITS = 16,
    parameter int POS_INT_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsp_pkg::dp_cmd_t              cmd,
    output lsp_pkg::dp_sts_t              sts,
    input  logic [lsp_pkg::TDATA_W-1:0]   s_tdata,
    input  logic [lsp_pkg::REG_W-1:0]     start_pos,
    input  logic [lsp_pkg::REG_W-1:0]     end_pos,
    input  logic [lsp_pkg::REG_W-1:0]     loop_begin,
    input  logic [lsp_pkg::REG_W-1:0]     loop_finish,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsp_pkg::REG_W-1:0]     m_tdata
);

    localparam int REG_W    = lsp_pkg::REG_W;
    localparam int TRIG_W   = lsp_pkg::TRIG_W;
    localparam int UP       = (POS_FRAC_BITS >= 16) ? (POS_FRAC_BITS - 16) : 0;
    localparam int DN       = (POS_FRAC_BITS < 16) ? (16 - POS_FRAC_BITS) : 0;
    localparam int RATE_W   = lsp_pkg::RATE_IN_W + UP;
    localparam int PH_W     = ((RATE_W > REG_W + 1) ? RATE_W : REG_W + 1) + 1;
    localparam int PROD_W   = TRIG_W + RATE_W;
    localparam int PMAG_W   = RATE_W + TRIG_W - 1;
    localparam int DVD_W    = (PMAG_W > PH_W) ? PMAG_W : PH_W;
    localparam int POS_BITS = POS_INT_BITS + POS_FRAC_BITS;
    localparam logic [REG_W-1:0] OUT_LIM =
        (POS_BITS >= REG_W) ? {REG_W{1'b1}} : REG_W'((64'd1 << POS_BITS) - 64'd1);

    // input fields
    logic signed [TRIG_W-1:0]     rtrig_in;
    logic signed [TRIG_W-1:0]     ftrig_in;
    logic signed [RATE_W-1:0]     rate_ext;
    logic signed [RATE_W-1:0]     rate_al;

    // item and phasor state
    logic signed [TRIG_W-1:0]     rtrig_reg;
    logic signed [TRIG_W-1:0]     ftrig_reg;
    logic signed [RATE_W-1:0]     rate_reg;
    logic signed [PH_W-1:0]       phase_reg;
    logic signed [TRIG_W-1:0]     last_r_reg;
    logic signed [TRIG_W-1:0]     last_f_reg;
    logic                         fmode_reg;
    logic                         first_reg;
    logic signed [PH_W-1:0]       lvl_reg;
    logic signed [PH_W-1:0]       lvl_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic [TRIG_W-1:0]            den_reg;
    logic signed [PH_W:0]         wd_reg;
    logic [REG_W-1:0]             lo_reg;
    logic [REG_W-1:0]             rng_reg;
    logic                         out_valid_reg;
    logic [REG_W-1:0]             out_data_reg;

    // config as signed positions
    logic signed [PH_W-1:0]       s_x;
    logic signed [PH_W-1:0]       e_x;
    logic signed [PH_W-1:0]       lb_x;
    logic signed [PH_W-1:0]       lf_x;

    logic                         restart_edge;
    logic                         finish_edge;
    logic signed [PROD_W-1:0]     prod_w;
    logic signed [TRIG_W:0]       den_w;

    logic                         prod_neg;
    logic [PROD_W-1:0]            prod_mag;
    logic                         wd_neg;
    logic [PH_W:0]                wd_mag;
    logic [DVD_W-1:0]             div_dvd;
    logic [REG_W-1:0]             div_dvs;
    logic                         div_busy;
    logic [DVD_W-1:0]             div_quo;
    logic [REG_W-1:0]             div_rem;

    logic signed [PH_W-1:0]       q_mag;
    logic signed [PH_W-1:0]       q_val;
    logic signed [PH_W-1:0]       clamp_lo;
    logic signed [PH_W-1:0]       clamp_val;
    logic                         in_loop;
    logic [REG_W-1:0]             lo_u;
    logic [REG_W-1:0]             hi_u;
    logic                         empty_rng;
    logic                         need_mod;
    logic signed [PH_W-1:0]       direct_val;
    logic [REG_W-1:0]             mod_val;
    logic [REG_W-1:0]             out_val;

    assign rtrig_in = $signed(s_tdata[TRIG_W-1:0]);
    assign ftrig_in = $signed(s_tdata[2*TRIG_W-1:TRIG_W]);
    assign rate_ext = RATE_W'($signed(s_tdata[lsp_pkg::TDATA_W-1:2*TRIG_W]));
    assign rate_al  = (rate_ext <<< UP) >>> DN;

    assign s_x  = $signed(PH_W'(start_pos));
    assign e_x  = $signed(PH_W'(end_pos));
    assign lb_x = $signed(PH_W'(loop_begin));
    assign lf_x = $signed(PH_W'(loop_finish));

    // trigger edges and restart offset operands
    assign restart_edge = !first_reg && (last_r_reg <= 16'sd0) && (rtrig_reg > 16'sd0);
    assign finish_edge  = !first_reg && (last_f_reg <= 16'sd0) && (ftrig_reg > 16'sd0);
    assign prod_w       = PROD_W'(rtrig_reg) * PROD_W'(rate_reg);
    assign den_w        = (TRIG_W+1)'(rtrig_reg) - (TRIG_W+1)'(last_r_reg);

    // divider operand select
    assign prod_neg = prod_reg[PROD_W-1];
    assign prod_mag = prod_neg ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign wd_neg   = wd_reg[PH_W];
    assign wd_mag   = wd_neg ? $unsigned(-wd_reg) : $unsigned(wd_reg);
    assign div_dvd  = (cmd.div_sel == lsp_pkg::DIV_WRAP) ? DVD_W'(wd_mag) : DVD_W'(prod_mag);
    assign div_dvs  = (cmd.div_sel == lsp_pkg::DIV_WRAP) ? rng_reg : REG_W'(den_reg);

    lsp_div #(
        .DVD_W (DVD_W),
        .DVS_W (REG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // floor of the signed restart offset
    assign q_mag = $signed(PH_W'(div_quo));
    assign q_val = prod_neg ? (-q_mag - $signed(PH_W'(div_rem != '0))) : q_mag;

    // wrap or clamp selection
    always_comb
    begin
        clamp_lo   = (lvl_reg < s_x) ? s_x : lvl_reg;
        clamp_val  = (clamp_lo > e_x) ? e_x : clamp_lo;
        in_loop    = (lvl_reg >= lb_x) && (lvl_reg <= lf_x);
        lo_u       = in_loop ? loop_begin : start_pos;
        hi_u       = in_loop ? loop_finish : end_pos;
        empty_rng  = (hi_u <= lo_u);
        need_mod   = !fmode_reg && !in_loop && !empty_rng;
        if (fmode_reg)
        begin
            direct_val = clamp_val;
        end
        else if (empty_rng)
        begin
            direct_val = $signed(PH_W'(lo_u));
        end
        else if (lvl_reg == lf_x)
        begin
            direct_val = lb_x;
        end
        else
        begin
            direct_val = lvl_reg;
        end
    end

    assign mod_val = wd_neg ? ((div_rem == '0) ? '0 : (rng_reg - div_rem)) : div_rem;
    assign out_val = (lvl_reg > $signed(PH_W'(OUT_LIM))) ? OUT_LIM : lvl_reg[REG_W-1:0];

    always_comb
    begin
        lvl_next = lvl_reg;
        if (cmd.eval)
        begin
            lvl_next = first_reg ? s_x : phase_reg;
        end
        else if (cmd.rfix)
        begin
            lvl_next = s_x + q_val;
        end
        else if (cmd.wrap)
        begin
            lvl_next = direct_val;
        end
        else if (cmd.mfix)
        begin
            lvl_next = $signed(PH_W'(lo_reg) + PH_W'(mod_val));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            last_r_reg    <= 16'sd1;
            last_f_reg    <= 16'sd1;
            fmode_reg     <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                fmode_reg  <= fmode_reg ^ finish_edge;
                first_reg  <= 1'b0;
                last_r_reg <= rtrig_reg;
                last_f_reg <= ftrig_reg;
            end
            if (cmd.out_write)
            begin
                phase_reg     <= lvl_reg + PH_W'(rate_reg);
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        if (cmd.load)
        begin
            rtrig_reg <= rtrig_in;
            ftrig_reg <= ftrig_in;
            rate_reg  <= rate_al;
        end
        if (cmd.eval)
        begin
            prod_reg <= prod_w;
            den_reg  <= den_w[TRIG_W-1:0];
        end
        if (cmd.wrap)
        begin
            wd_reg  <= (PH_W+1)'(lvl_reg) - $signed((PH_W+1)'(lo_u));
            lo_reg  <= lo_u;
            rng_reg <= hi_u - lo_u;
        end
        if (cmd.out_write)
        begin
            out_data_reg <= out_val;
        end
    end

    assign sts.restart_edge = restart_edge;
    assign sts.need_mod     = need_mod;
    assign sts.div_busy     = div_busy;
    assign sts.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/looping_sample_phasor_core.sv @@
`timescale 1ns / 1ps
// looping_sample_phasor_core: top level with config registers, sequencer and datapath
// depends on lsp_pkg, lsp_ctrl, lsp_dp (and lsp_div through lsp_dp)
// one item in flight; an item passes EVAL, WRAP and OUT before the next ready, plus the
// restart division (RDIV_GO, RDIV, RFIX) when a restart edge needs the offset, and the
// modulo division (MDIV_GO, MDIV, MFIX) when, outside finish mode, the position lies
// outside the loop region (modulo wrap); DVD_W is 47 at the default widths
// both divisions share one serial divider; a result waits in the output register
// reset: async active low; config to defaults, phasor waits for its first sample

module looping_sample_phasor_core #(
    parameter int POS_FRAC_BITS = 16,
    parameter int POS_INT_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // restart_trig [15:0], finish_trig [31:16], step_rate [63:32]
    input  logic [lsp_pkg::TDATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // position [39:0]
    output logic [lsp_pkg::REG_W-1:0]     m_tdata,
    input  logic                          cfg_we,
    input  logic [lsp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [lsp_pkg::REG_W-1:0]     cfg_data
);

    logic [lsp_pkg::REG_W-1:0] start_pos_reg;
    logic [lsp_pkg::REG_W-1:0] end_pos_reg;
    logic [lsp_pkg::REG_W-1:0] loop_begin_reg;
    logic [lsp_pkg::REG_W-1:0] loop_finish_reg;

    lsp_pkg::cfg_idx_t cfg_idx;
    lsp_pkg::dp_cmd_t  cmd;
    lsp_pkg::dp_sts_t  sts;

    assign cfg_idx = lsp_pkg::cfg_idx_t'(cfg_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg   <= '0;
            end_pos_reg     <= '1;
            loop_begin_reg  <= '0;
            loop_finish_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                lsp_pkg::CFG_START_POS:   start_pos_reg   <= cfg_data;
                lsp_pkg::CFG_END_POS:     end_pos_reg     <= cfg_data;
                lsp_pkg::CFG_LOOP_BEGIN:  loop_begin_reg  <= cfg_data;
                lsp_pkg::CFG_LOOP_FINISH: loop_finish_reg <= cfg_data;
            endcase
        end
    end

    lsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsp_dp #(
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .POS_INT_BITS  (POS_INT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .start_pos   (start_pos_reg),
        .end_pos     (end_pos_reg),
        .loop_begin  (loop_begin_reg),
        .loop_finish (loop_finish_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ rtl/lsp_chk.sv @@
`timescale 1ns / 1ps
// lsp_chk: port-level checks of the looping sample phasor
// depends on lsp_pkg; bound to looping_sample_phasor_core

module lsp_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [lsp_pkg::REG_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a new result only comes out of a busy cycle
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

    // reset empties the block
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && s_tready)
        else $error("block not idle in reset");

endmodule

bind looping_sample_phasor_core lsp_chk u_lsp_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for looping_sample_phasor_core, predicts each position in step
// with the stream transfers; depends on lsp_pkg and the core rtl

module tb;

    import lsp_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS = 24;
    localparam longint POS_MAX = (64'sd1 <<< (INT_BITS + FRAC_BITS)) - 1;
    localparam longint OUT_MAX = (64'sd1 <<< REG_W) - 1;
    localparam logic [REG_W-1:0] ONE_FRAME = 40'h1_0000;
    localparam int FRAME_RATE = 32'h1_0000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 115;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // restart_trig [15:0], finish_trig [31:16], step_rate [63:32]
    logic [TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // position [39:0]
    logic [REG_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [REG_W-1:0] cfg_data = '0;

    // predicted register contents and phasor state
    logic [REG_W-1:0] reg_start = '0;
    logic [REG_W-1:0] reg_end = '1;
    logic [REG_W-1:0] reg_loop_lo = '0;
    logic [REG_W-1:0] reg_loop_hi = '1;
    longint phase_acc = 0;
    longint prev_restart = 1;
    longint prev_finish = 1;
    bit finishing = 1'b0;
    bit awaiting_first = 1'b1;

    logic [REG_W-1:0] expected_positions[$];
    logic [REG_W-1:0] want;
    logic [TRIG_W-1:0] last_rt = '0;
    logic [TRIG_W-1:0] last_ft = '0;
    bit steady = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned restarts = 0;
    int unsigned toggles = 0;
    int unsigned finish_items = 0;
    int unsigned settings = 0;

    looping_sample_phasor_core #(
        .POS_FRAC_BITS(FRAC_BITS),
        .POS_INT_BITS (INT_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint wrap_into(input longint x, input longint lo, input longint hi);
        longint span;
        longint m;
        if (hi <= lo)
        begin
            return lo;
        end
        span = hi - lo;
        m = (x - lo) % span;
        if (m < 0)
        begin
            m += span;
        end
        return lo + m;
    endfunction

    function automatic logic [REG_W-1:0] predict_position(
        input logic signed [TRIG_W-1:0] rt,
        input logic signed [TRIG_W-1:0] ft,
        input logic signed [RATE_IN_W-1:0] rate_in
    );
        longint rate;
        longint lvl;
        longint s;
        longint e;
        longint lo;
        longint hi;
        longint prod;
        longint den;
        longint quo;
        longint o;
        rate = rate_in;
        if (FRAC_BITS >= 16)
        begin
            rate = rate <<< (FRAC_BITS - 16);
        end
        else
        begin
            rate = rate >>> (16 - FRAC_BITS);
        end
        s = reg_start;
        e = reg_end;
        lo = reg_loop_lo;
        hi = reg_loop_hi;
        lvl = phase_acc;
        if (awaiting_first)
        begin
            lvl = s;
            awaiting_first = 1'b0;
        end
        else
        begin
            if (prev_restart <= 0 && rt > 0)
            begin
                // sub-sample offset, floor of cur * rate / (cur - prev)
                prod = longint'(rt) * rate;
                den = longint'(rt) - prev_restart;
                quo = prod / den;
                if ((prod % den) != 0 && prod < 0)
                begin
                    quo--;
                end
                lvl = s + quo;
                restarts++;
            end
            if (prev_finish <= 0 && ft > 0)
            begin
                finishing = !finishing;
                toggles++;
            end
        end
        if (!finishing)
        begin
            if (lvl >= lo && lvl <= hi)
            begin
                lvl = wrap_into(lvl, lo, hi);
            end
            else
            begin
                lvl = wrap_into(lvl, s, e);
            end
        end
        else
        begin
            finish_items++;
            if (lvl < s)
            begin
                lvl = s;
            end
            if (lvl > e)
            begin
                lvl = e;
            end
        end
        o = lvl;
        if (o < 0)
        begin
            o = 0;
        end
        if (o > POS_MAX)
        begin
            o = POS_MAX;
        end
        if (o > OUT_MAX)
        begin
            o = OUT_MAX;
        end
        phase_acc = lvl + rate;
        prev_restart = rt;
        prev_finish = ft;
        return o[REG_W-1:0];
    endfunction

    function automatic logic [TRIG_W-1:0] next_trig(
        input logic signed [TRIG_W-1:0] prev,
        input int unsigned cross_pct
    );
        int unsigned r;
        int unsigned mag;
        bit go_pos;
        r = $urandom_range(99);
        if (r < 6)
        begin
            return TRIG_W'($urandom);
        end
        go_pos = (prev > 0) ^ (r < 6 + cross_pct);
        mag = ($urandom_range(1) != 0) ? 8 : 32767;
        if (go_pos)
        begin
            return TRIG_W'($urandom_range(1, mag));
        end
        return TRIG_W'(0 - $urandom_range(0, mag + 1));
    endfunction

    function automatic logic [RATE_IN_W-1:0] next_rate(input int unsigned lim);
        int unsigned r;
        int unsigned mag;
        r = $urandom_range(99);
        if (r < 8)
        begin
            return $urandom;
        end
        mag = (r < 16) ? $urandom_range(0, 4) : $urandom_range(0, lim);
        if ($urandom_range(3) == 0)
        begin
            return 0 - mag;
        end
        return mag;
    endfunction

    task automatic send_item(
        input logic [TRIG_W-1:0] rt,
        input logic [TRIG_W-1:0] ft,
        input logic [RATE_IN_W-1:0] rate
    );
        @(negedge clk);
        while (!steady && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rate, ft, rt};
        do @(posedge clk); while (!s_tready);
        expected_positions.push_back(predict_position(rt, ft, rate));
        items_sent++;
        last_rt = rt;
        last_ft = ft;
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            CFG_START_POS:   reg_start = val;
            CFG_END_POS:     reg_end = val;
            CFG_LOOP_BEGIN:  reg_loop_lo = val;
            CFG_LOOP_FINISH: reg_loop_hi = val;
            default:         ;
        endcase
    endtask

    task automatic set_regs(
        input logic [REG_W-1:0] s,
        input logic [REG_W-1:0] e,
        input logic [REG_W-1:0] lo,
        input logic [REG_W-1:0] hi
    );
        wait_results_done();
        write_reg(CFG_START_POS, s);
        write_reg(CFG_END_POS, e);
        write_reg(CFG_LOOP_BEGIN, lo);
        write_reg(CFG_LOOP_FINISH, hi);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // reset registers: first item, trigger extremes, rate extremes, wrap below zero
    task automatic test_reset_defaults();
        settings++;
        send_item(16'h7fff, 16'h7fff, 32'h0001_0000);
        send_item(16'h0000, 16'h0000, 32'h7fff_ffff);
        send_item(16'h0001, 16'h0001, 32'h8000_0000);
        send_item(16'h8000, 16'h8000, 32'hffff_ffff);
        send_item(16'h7fff, 16'h0000, 32'hfffd_0000);
        send_item(16'h0000, 16'h7fff, 32'hfffd_0000);
        send_item(16'h0000, 16'h7fff, 32'hffff_0000);
    endtask

    // loop region inside playback range, clamping, empty and inverted ranges
    task automatic test_wrap_and_clamp();
        set_regs(100 * ONE_FRAME, 200 * ONE_FRAME, 120 * ONE_FRAME, 150 * ONE_FRAME);
        send_item(16'h4000, 16'h4000, 7 * FRAME_RATE);
        repeat (4) send_item(16'h4000, 16'h4000, 7 * FRAME_RATE);
        send_item(16'hc000, 16'h4000, 7 * FRAME_RATE);
        send_item(16'h2000, 16'h4000, 7 * FRAME_RATE);
        send_item(16'h2000, 16'h8000, 60 * FRAME_RATE);
        send_item(16'h2000, 16'h0001, 60 * FRAME_RATE);
        send_item(16'h2000, 16'h0001, -90 * FRAME_RATE);
        send_item(16'h2000, 16'h8000, -90 * FRAME_RATE);
        send_item(16'h2000, 16'h7fff, 5 * FRAME_RATE);
        set_regs(50 * ONE_FRAME, 50 * ONE_FRAME, 90 * ONE_FRAME, 80 * ONE_FRAME);
        repeat (3) send_item(16'h2000, 16'h7fff, 5 * FRAME_RATE);
        set_regs(300 * ONE_FRAME, 200 * ONE_FRAME, '0, '0);
        send_item(16'h2000, 16'h8000, FRAME_RATE);
        send_item(16'h2000, 16'h0100, FRAME_RATE);
        send_item(16'h2000, 16'h0100, FRAME_RATE);
    endtask

    // random register settings, each followed by a run of trigger and rate sequences
    task automatic test_random_settings();
        logic [REG_W-1:0] s;
        logic [REG_W-1:0] e;
        logic [REG_W-1:0] lo;
        logic [REG_W-1:0] hi;
        longint span;
        int unsigned rate_lim;
        int unsigned cross_r;
        int unsigned cross_f;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            span = (longint'($urandom_range(1, 300)) << 16) | $urandom_range(0, 65535);
            s = (REG_W'($urandom_range(0, 5000)) << 16) | REG_W'($urandom_range(0, 65535));
            e = REG_W'(s + span);
            lo = REG_W'(s + longint'($urandom_range(0, 1000)) * span / 1000);
            hi = REG_W'(lo + longint'($urandom_range(0, 1000)) * span / 1000);
            rate_lim = $urandom_range(1, 12) << 16;
            case (p % 4)
                2:
                begin
                    s = REG_W'({$urandom, $urandom});
                    e = REG_W'({$urandom, $urandom});
                    lo = REG_W'({$urandom, $urandom});
                    hi = REG_W'({$urandom, $urandom});
                    rate_lim = 32'h7fff_ffff;
                end
                3:
                begin
                    if (p == 3)
                    begin
                        s = '0;
                        e = '0;
                        lo = '0;
                        hi = '0;
                    end
                    else if (p == 7)
                    begin
                        s = '1;
                        e = '1;
                        lo = '1;
                        hi = '1;
                    end
                    else
                    begin
                        e = s;
                        lo = hi + ONE_FRAME;
                    end
                end
                default: ;
            endcase
            set_regs(s, e, lo, hi);
            // one phase runs with neither side idling
            steady = (p == 5);
            cross_r = $urandom_range(2, 35);
            cross_f = $urandom_range(1, 12);
            repeat (PHASE_ITEMS)
            begin
                send_item(next_trig(last_rt, cross_r), next_trig(last_ft, cross_f),
                          next_rate(rate_lim));
            end
            steady = 1'b0;
        end
        set_regs('0, '1, '0, '1);
        repeat (20)
        begin
            send_item(next_trig(last_rt, 20), next_trig(last_ft, 5), next_rate(32'h7fff_ffff));
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, expected_positions.size());
            $display("Some tests failed");
            $finish;
        end
        else if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_positions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d: position %h with none expected", results_seen, m_tdata);
                end
            end
            else
            begin
                want = expected_positions.pop_front();
                if (m_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: position expected %h got %h",
                                 results_seen, want, m_tdata);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_wrap_and_clamp();
        test_random_settings();
        wait_results_done();
        repeat (110) @(posedge clk);
        $display("run covered %0d items and %0d results over %0d register settings",
                 items_sent, results_seen, settings);
        $display("%0d restart edges, %0d finish toggles, %0d items in finish mode",
                 restarts, toggles, finish_items);
        if (mismatches == 0 && expected_positions.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_positions.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
